// ===== rtl/core/k_way_min_merge_macros.svh =====
// ---------------------------------------------------------------------------
// k_way_min_merge assertion macros
// Concurrent checks used by the merge core; all drop out with NO_ASSERTIONS.
// ---------------------------------------------------------------------------
`ifndef K_WAY_MIN_MERGE_MACROS_SVH
`define K_WAY_MIN_MERGE_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define KWM_ASSERT_IMPLY(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rst_n_s)) (ante) |-> (cons)) \
		else $error("kwm check failed");

// next-cycle implication
`define KWM_ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rst_n_s)) (ante) |=> (cons)) \
		else $error("kwm check failed");

`else

`define KWM_ASSERT_IMPLY(lbl, clk_s, rst_n_s, ante, cons)
`define KWM_ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons)

`endif

`endif

// ===== rtl/core/kwm_pkg.sv =====
// ---------------------------------------------------------------------------
// kwm_pkg
// Shared widths, register map, state type and status struct of the merge core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kwm_pkg;

	localparam int KEY_W      = 31;
	localparam int TAG_W      = 32;
	localparam int WAY_W      = 5;
	localparam int CFG_W      = 6;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;
	localparam int WAYS_DEF   = 32;

	localparam logic [CFG_W-1:0] WAYS_IN_USE_RST = 6'd21;

	// register index, taken from paddr[2]
	localparam logic REG_WAYS_IN_USE = 1'b0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_SCAN,
		ST_EMIT
	} kwm_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} scan_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/kwm_mem.sv =====
// ---------------------------------------------------------------------------
// kwm_mem
// Head record store: one key/tag entry per way, one write and one read port,
// registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kwm_mem #(
	parameter int WAYS = kwm_pkg::WAYS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          we,
	input  wire logic [$clog2(WAYS)-1:0]       waddr,
	input  wire logic [kwm_pkg::KEY_W-1:0]     wkey,
	input  wire logic [kwm_pkg::TAG_W-1:0]     wtag,
	input  wire logic                          re,
	input  wire logic [$clog2(WAYS)-1:0]       raddr,
	output logic      [kwm_pkg::KEY_W-1:0]     rkey,
	output logic      [kwm_pkg::TAG_W-1:0]     rtag
);

	localparam int ENT_W = kwm_pkg::KEY_W + kwm_pkg::TAG_W;

	logic [ENT_W-1:0] mem [WAYS];
	logic [ENT_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= {wkey, wtag};
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rkey = rdata_q[ENT_W-1:kwm_pkg::TAG_W];
	assign rtag = rdata_q[kwm_pkg::TAG_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/core/kwm_scan.sv =====
// ---------------------------------------------------------------------------
// kwm_scan
// Minimum search: walks the head store one way per cycle and keeps the
// smallest key of the unfinished ways, lowest way on ties.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kwm_scan #(
	parameter int WAYS = kwm_pkg::WAYS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic [$clog2(WAYS+1)-1:0]         n_eff,
	input  wire logic [WAYS-1:0]                   fin,
	output logic                                   rd_en,
	output logic      [$clog2(WAYS)-1:0]           rd_addr,
	input  wire logic [kwm_pkg::KEY_W-1:0]         rd_key,
	input  wire logic [kwm_pkg::TAG_W-1:0]         rd_tag,
	output kwm_pkg::scan_stat_t                    stat,
	output logic      [$clog2(WAYS)-1:0]           best_idx,
	output logic      [kwm_pkg::KEY_W-1:0]         best_key,
	output logic      [kwm_pkg::TAG_W-1:0]         best_tag
);

	localparam int NW   = $clog2(WAYS + 1);
	localparam int WIDX = $clog2(WAYS);

	logic [NW-1:0]            idx_q;
	logic                     issuing_q;
	logic                     v_s1;
	logic [WIDX-1:0]          i_s1;
	logic                     last_s1;
	logic                     done_q;
	logic                     found_q;
	logic [WIDX-1:0]          best_idx_q;
	logic [kwm_pkg::KEY_W-1:0] best_key_q;
	logic [kwm_pkg::TAG_W-1:0] best_tag_q;
	logic                     last_issue;
	logic                     take;

	assign last_issue = (idx_q == n_eff - NW'(1));
	// strict less-than keeps the lower way on equal keys
	assign take = v_s1 && !fin[i_s1] && (!found_q || (rd_key < best_key_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issuing_q <= 1'b0;
			idx_q     <= '0;
			v_s1      <= 1'b0;
			done_q    <= 1'b0;
			found_q   <= 1'b0;
		end else begin
			v_s1   <= issuing_q;
			done_q <= v_s1 && last_s1;
			if (start) begin
				issuing_q <= 1'b1;
				idx_q     <= '0;
				found_q   <= 1'b0;
			end else begin
				if (issuing_q) begin
					idx_q <= idx_q + NW'(1);
					if (last_issue) begin
						issuing_q <= 1'b0;
					end
				end
				if (take) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		i_s1    <= idx_q[WIDX-1:0];
		last_s1 <= last_issue;
		if (take) begin
			best_idx_q <= i_s1;
			best_key_q <= rd_key;
			best_tag_q <= rd_tag;
		end
	end

	assign rd_en     = issuing_q;
	assign rd_addr   = idx_q[WIDX-1:0];
	assign stat.busy = issuing_q | v_s1;
	assign stat.done = done_q;
	assign best_idx  = best_idx_q;
	assign best_key  = best_key_q;
	assign best_tag  = best_tag_q;

endmodule

`default_nettype wire

// ===== rtl/core/k_way_min_merge.sv =====
// ---------------------------------------------------------------------------
// k_way_min_merge
// Merges up to WAYS sorted runs: holds one head per way, emits the smallest
// head once all unfinished ways hold one, and a done word when all finish.
// ---------------------------------------------------------------------------
//  channel  | handshake                | payload
//  ---------+--------------------------+-----------------------------------------
//  in       | in_valid / in_stall      | way, record_key, record_tag, exhausted
//  out      | out_valid / out_stall    | out_key, out_tag, refill_way, merge_done
//  cfg      | psel/penable/pwrite/...  | ways_in_use at byte address 0
//
//  A word that yields no result passes through accept and evaluate.
//  A word that yields a record also passes through a minimum search, which
//  reads the head store one way per cycle on its single read port.
//  A done word clears the valid and finished flags at once.
//  in_stall is high after acceptance until the result is loaded into the output
//  register or no result is due; a stalled output holds the core in its evaluate or emit state.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "k_way_min_merge_macros.svh"

module k_way_min_merge #(
	parameter int WAYS = kwm_pkg::WAYS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// input words
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [kwm_pkg::WAY_W-1:0]         way,
	input  wire logic [kwm_pkg::KEY_W-1:0]         record_key,
	input  wire logic [kwm_pkg::TAG_W-1:0]         record_tag,
	input  wire logic                              exhausted,
	// result words
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic      [kwm_pkg::KEY_W-1:0]         out_key,
	output logic      [kwm_pkg::TAG_W-1:0]         out_tag,
	output logic      [kwm_pkg::WAY_W-1:0]         refill_way,
	output logic                                   merge_done,
	// configuration
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [kwm_pkg::APB_ADDR_W-1:0]    paddr,
	input  wire logic [kwm_pkg::APB_DATA_W-1:0]    pwdata,
	output logic      [kwm_pkg::APB_DATA_W-1:0]    prdata,
	output logic                                   pready
);

	localparam int NW   = $clog2(WAYS + 1);
	localparam int WIDX = $clog2(WAYS);

	kwm_pkg::kwm_state_t state_q, state_d;

	logic [kwm_pkg::CFG_W-1:0] ways_q;
	logic [WAYS-1:0]           valid_q;
	logic [WAYS-1:0]           fin_q;
	logic [WAYS-1:0]           in_use;

	logic [7:0]      cfg8;
	logic [7:0]      cap8;
	logic [7:0]      n8;
	logic [7:0]      way8;
	logic [NW-1:0]   n_eff;
	logic [WIDX-1:0] widx;
	logic            in_range;
	logic            in_acc;
	logic            upd;
	logic            all_done;
	logic            all_ready;

	logic            out_valid_q;
	logic [kwm_pkg::KEY_W-1:0] out_key_q;
	logic [kwm_pkg::TAG_W-1:0] out_tag_q;
	logic [kwm_pkg::WAY_W-1:0] refill_q;
	logic            done_q;
	logic            out_free;
	logic            load_done;
	logic            load_rec;
	logic            scan_start;
	logic [7:0]      best8;

	logic                      rd_en;
	logic [WIDX-1:0]           rd_addr;
	logic [kwm_pkg::KEY_W-1:0] rd_key;
	logic [kwm_pkg::TAG_W-1:0] rd_tag;
	kwm_pkg::scan_stat_t       scan_stat;
	logic [WIDX-1:0]           best_idx;
	logic [kwm_pkg::KEY_W-1:0] best_key;
	logic [kwm_pkg::TAG_W-1:0] best_tag;

	logic cfg_hit;
	logic cfg_wr;

	// ---- configuration port ----
	assign pready  = 1'b1;
	assign cfg_hit = (paddr[2] == kwm_pkg::REG_WAYS_IN_USE);
	assign cfg_wr  = psel && penable && pwrite && cfg_hit;
	assign prdata  = cfg_hit ? kwm_pkg::APB_DATA_W'(ways_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ways_q <= kwm_pkg::WAYS_IN_USE_RST;
		end else if (cfg_wr) begin
			ways_q <= pwdata[kwm_pkg::CFG_W-1:0];
		end
	end

	// effective way count: 0 acts as 1, clipped to WAYS
	assign cfg8  = 8'(ways_q);
	assign cap8  = 8'(WAYS);
	assign n8    = (cfg8 == 8'd0) ? 8'd1 : ((cfg8 > cap8) ? cap8 : cfg8);
	assign n_eff = n8[NW-1:0];

	assign way8     = 8'(way);
	assign in_range = (way8 < n8);
	assign widx     = way8[WIDX-1:0];
	assign in_acc   = in_valid && !in_stall;
	assign upd      = in_acc && in_range && !valid_q[widx] && !fin_q[widx];

	always_comb begin
		for (int i = 0; i < WAYS; i++) begin
			in_use[i] = (8'(i) < n8);
		end
	end

	assign all_done  = &(fin_q | ~in_use);
	assign all_ready = &(fin_q | valid_q | ~in_use);

	// ---- control ----
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != kwm_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kwm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		load_done  = 1'b0;
		load_rec   = 1'b0;
		scan_start = 1'b0;
		case (state_q)
			kwm_pkg::ST_IDLE: begin
				if (in_acc) begin
					state_d = kwm_pkg::ST_EVAL;
				end
			end
			kwm_pkg::ST_EVAL: begin
				if (all_done) begin
					if (out_free) begin
						load_done = 1'b1;
						state_d   = kwm_pkg::ST_IDLE;
					end
				end else if (all_ready) begin
					scan_start = 1'b1;
					state_d    = kwm_pkg::ST_SCAN;
				end else begin
					state_d = kwm_pkg::ST_IDLE;
				end
			end
			kwm_pkg::ST_SCAN: begin
				if (scan_stat.done) begin
					state_d = kwm_pkg::ST_EMIT;
				end
			end
			kwm_pkg::ST_EMIT: begin
				if (out_free) begin
					load_rec = 1'b1;
					state_d  = kwm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = kwm_pkg::ST_IDLE;
			end
		endcase
	end

	// ---- per-way flags ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			fin_q   <= '0;
		end else if (load_done) begin
			valid_q <= '0;
			fin_q   <= '0;
		end else begin
			if (upd) begin
				if (exhausted) begin
					fin_q[widx] <= 1'b1;
				end else begin
					valid_q[widx] <= 1'b1;
				end
			end
			if (load_rec) begin
				valid_q[best_idx] <= 1'b0;
			end
		end
	end

	// ---- head store and search; input is stalled during a scan ----
	kwm_mem #(
		.WAYS (WAYS)
	) u_mem (
		.clk   (clk),
		.we    (upd && !exhausted),
		.waddr (widx),
		.wkey  (record_key),
		.wtag  (record_tag),
		.re    (rd_en),
		.raddr (rd_addr),
		.rkey  (rd_key),
		.rtag  (rd_tag)
	);

	kwm_scan #(
		.WAYS (WAYS)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (scan_start),
		.n_eff    (n_eff),
		.fin      (fin_q),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_key   (rd_key),
		.rd_tag   (rd_tag),
		.stat     (scan_stat),
		.best_idx (best_idx),
		.best_key (best_key),
		.best_tag (best_tag)
	);

	// ---- output register ----
	assign best8 = 8'(best_idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_done || load_rec) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_done) begin
			out_key_q <= '0;
			out_tag_q <= '0;
			refill_q  <= '0;
			done_q    <= 1'b1;
		end else if (load_rec) begin
			out_key_q <= best_key;
			out_tag_q <= best_tag;
			refill_q  <= best8[kwm_pkg::WAY_W-1:0];
			done_q    <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_key    = out_key_q;
	assign out_tag    = out_tag_q;
	assign refill_way = refill_q;
	assign merge_done = done_q;

	// ---- checks ----
	`KWM_ASSERT_IMPLY(a_load_slot_free, clk, arst_n, (load_done || load_rec), out_free)
	`KWM_ASSERT_IMPLY(a_emit_head_valid, clk, arst_n, load_rec, (valid_q[best_idx] && !fin_q[best_idx]))
	`KWM_ASSERT_NEXT(a_done_clears, clk, arst_n, load_done, ((valid_q == '0) && (fin_q == '0)))
	`KWM_ASSERT_IMPLY(a_scan_in_state, clk, arst_n, scan_stat.busy, (state_q == kwm_pkg::ST_SCAN))

endmodule

`default_nettype wire

// ===== test/k_way_min_merge_test.sv =====
// ----------------------------------------------------------------------------
// k_way_min_merge_test
// Self-checking bench for the k-way min merge. Runs of sorted records and
// exhausted marks go in through a bursty driver, mixed with stray words. A
// predictor scores every accepted input word. Each result word is checked
// field by field against the oldest prediction. The ways_in_use setting
// changes between phases, and this includes its out-of-range values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module k_way_min_merge_test;
	import kwm_pkg::*;

	localparam int WAYS = WAYS_DEF;
	localparam int SETTLE = 2 * WAYS + 16;  // longer than one record scan
	localparam int RANDOM_WORDS = 1500;
	localparam logic [APB_ADDR_W-1:0] WAYS_ADDR = {REG_WAYS_IN_USE, 2'b00};
	localparam logic [KEY_W-1:0] KEY_MAX = '1;

	typedef struct packed {
		logic [WAY_W-1:0] way;
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
		logic             ex;
	} merge_word_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
		logic [WAY_W-1:0] refill;
		logic             done;
	} merge_out_t;

	typedef struct packed {
		logic [CFG_W-1:0]            ways_reg;
		logic [WAYS-1:0][KEY_W-1:0]  key;
		logic [WAYS-1:0][TAG_W-1:0]  tag;
		logic [WAYS-1:0]             held;
		logic [WAYS-1:0]             fin;
	} merge_state_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [WAY_W-1:0]      way = '0;
	logic [KEY_W-1:0]      record_key = '0;
	logic [TAG_W-1:0]      record_tag = '0;
	logic                  exhausted = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [KEY_W-1:0]      out_key;
	logic [TAG_W-1:0]      out_tag;
	logic [WAY_W-1:0]      refill_way;
	logic                  merge_done;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	merge_word_t  pending_words[$];
	merge_out_t   expected_emits[$];
	merge_state_t merge_model;  // follows accepted words
	merge_state_t merge_plan;   // follows generated words, steers the stimulus
	merge_word_t  tx_word;
	merge_word_t  rx_word;
	merge_out_t   predicted;
	merge_out_t   oldest;
	int           errors = 0;
	int           plan_words = 0;
	int           burst_left = 1;
	int           gap_left = 0;
	int           rx_cycle = 0;
	int           hold_left = 0;
	int           stall_mode = 0;

	k_way_min_merge dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .way(way), .record_key(record_key),
		.record_tag(record_tag), .exhausted(exhausted),
		.out_valid(out_valid), .out_stall(out_stall), .out_key(out_key), .out_tag(out_tag),
		.refill_way(refill_way), .merge_done(merge_done),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready)
	);

	function automatic int active_ways(input logic [CFG_W-1:0] r);
		if (r == 0)
			return 1;
		if (r > WAYS)
			return WAYS;
		return int'(r);
	endfunction

	// Apply one input word to a merge state; returns 1 when a result word comes out.
	function automatic bit merge_step(inout merge_state_t s, input merge_word_t w,
			output merge_out_t r);
		int n;
		int best;
		bit found;
		bit all_fin;
		bit all_held;
		n = active_ways(s.ways_reg);
		best = 0;
		found = 0;
		all_fin = 1;
		all_held = 1;
		r = '0;
		if (int'(w.way) < n && !s.held[w.way] && !s.fin[w.way]) begin
			if (w.ex) begin
				s.fin[w.way] = 1'b1;
			end else begin
				s.key[w.way] = w.key;
				s.tag[w.way] = w.tag;
				s.held[w.way] = 1'b1;
			end
		end
		for (int i = 0; i < n; i++) begin
			if (!s.fin[i]) begin
				all_fin = 0;
				if (!s.held[i])
					all_held = 0;
				else if (!found || s.key[i] < s.key[best]) begin
					found = 1;
					best = i;
				end
			end
		end
		if (all_fin) begin
			r.done = 1'b1;
			s.key = '0;
			s.tag = '0;
			s.held = '0;
			s.fin = '0;
			return 1;
		end
		if (all_held && found) begin
			r.key = s.key[best];
			r.tag = s.tag[best];
			r.refill = WAY_W'(best);
			s.held[best] = 1'b0;
			return 1;
		end
		return 0;
	endfunction

	task automatic feed(input logic [WAY_W-1:0] wy, input logic [KEY_W-1:0] k,
			input logic [TAG_W-1:0] t, input logic e, output bit done_seen);
		merge_word_t w;
		merge_out_t r;
		w = '{way: wy, key: k, tag: t, ex: e};
		pending_words.insert(pending_words.size(), w);
		done_seen = merge_step(merge_plan, w, r) && r.done;
	endtask

	// One merge: each way gets a sorted run; the next word goes to a way that
	// lacks a head, with some stray words mixed in.
	task automatic gen_merge(input int budget);
		int n;
		int rem[WAYS];
		longint last[WAYS];
		int step_max;
		int needs[$];
		int pick;
		int key_mode;
		bit done_seen;
		n = active_ways(merge_plan.ways_reg);
		key_mode = $urandom_range(0, 3);
		step_max = (key_mode == 0 || key_mode == 3) ? 2 : (1 << 20);
		for (int i = 0; i < WAYS; i++) begin
			rem[i] = $urandom_range(0, ($urandom_range(0, 4) == 0) ? 12 : 4);
			case (key_mode)
				0: last[i] = $urandom_range(0, 3);
				3: last[i] = longint'(KEY_MAX) - $urandom_range(0, 40);
				default: last[i] = $urandom_range(0, 32'h3fff_ffff);
			endcase
		end
		for (int k = 0; k < budget; k++) begin
			needs.delete();
			for (int i = 0; i < n; i++)
				if (!merge_plan.held[i] && !merge_plan.fin[i])
					needs.insert(needs.size(), i);
			if (needs.size() == 0 || $urandom_range(0, 9) == 0) begin
				feed(WAY_W'($urandom), KEY_W'($urandom), $urandom, $urandom_range(0, 5) == 0,
					done_seen);
			end else begin
				pick = needs[$urandom_range(0, needs.size() - 1)];
				plan_words++;
				if (rem[pick] == 0) begin
					feed(WAY_W'(pick), KEY_W'($urandom), $urandom, 1'b1, done_seen);
				end else begin
					feed(WAY_W'(pick), KEY_W'(last[pick]), $urandom, 1'b0, done_seen);
					rem[pick]--;
					last[pick] += $urandom_range(0, step_max);
					if (last[pick] > longint'(KEY_MAX))
						last[pick] = longint'(KEY_MAX);
				end
			end
			if (done_seen)
				break;
		end
	endtask

	task automatic write_ways(input logic [CFG_W-1:0] v);
		logic [APB_DATA_W-1:0] data;
		data = $urandom;
		data[CFG_W-1:0] = v;
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= WAYS_ADDR;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		merge_model.ways_reg = v;
		merge_plan.ways_reg = v;
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_words.size() != 0 || in_valid || expected_emits.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic field_mismatch(input string field, input logic [TAG_W-1:0] want,
			input logic [TAG_W-1:0] got);
		$display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
		errors++;
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1500000;
		$display("simulation failed");
		$finish;
	end

	// sender: bursts of random length, random gaps between them
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			way <= '0;
			record_key <= '0;
			record_tag <= '0;
			exhausted <= 1'b0;
			burst_left = 1;
			gap_left = 0;
		end else if (!in_valid || !in_stall) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_words.size() != 0) begin
				tx_word = pending_words.pop_front();
				in_valid <= 1'b1;
				way <= tx_word.way;
				record_key <= tx_word.key;
				record_tag <= tx_word.tag;
				exhausted <= tx_word.ex;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: the stall mode is redrawn periodically, plus a long hold now and then
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_cycle = 0;
			hold_left = 0;
			stall_mode = 0;
		end else begin
			rx_cycle++;
			if (rx_cycle % 600 == 0)
				stall_mode = $urandom_range(0, 3);
			if (rx_cycle % 16384 == 6000)
				hold_left = $urandom_range(300, 500);
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				case (stall_mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 4) == 0);
					2: out_stall <= ($urandom_range(0, 9) < 7);
					default: out_stall <= rx_cycle[2];
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				rx_word = '{way: way, key: record_key, tag: record_tag, ex: exhausted};
				if (merge_step(merge_model, rx_word, predicted))
					expected_emits.insert(expected_emits.size(), predicted);
			end
			if (out_valid && !out_stall) begin
				if (expected_emits.size() == 0) begin
					$display("%0t ns: unexpected word, expected none, actual key %h tag %h way %0d done %b",
						$time, out_key, out_tag, refill_way, merge_done);
					errors++;
				end else begin
					oldest = expected_emits.pop_front();
					if (out_key !== oldest.key)
						field_mismatch("out_key", oldest.key, out_key);
					if (out_tag !== oldest.tag)
						field_mismatch("out_tag", oldest.tag, out_tag);
					if (refill_way !== oldest.refill)
						field_mismatch("refill_way", oldest.refill, refill_way);
					if (merge_done !== oldest.done)
						field_mismatch("merge_done", oldest.done, merge_done);
				end
			end
		end
	end

	initial begin
		int phase;
		logic [CFG_W-1:0] v;
		bit done_seen;
		merge_model = '0;
		merge_model.ways_reg = WAYS_IN_USE_RST;
		merge_plan = merge_model;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		repeat (4) @(posedge clk);

		// two ways: unused way, repeat on a held head, ties, largest key, finished way
		write_ways(6'd2);
		feed(5'd5, 31'd123, 32'h1234_5678, 1'b0, done_seen);
		feed(5'd31, KEY_MAX, '1, 1'b0, done_seen);
		feed(5'd0, '0, '0, 1'b0, done_seen);
		feed(5'd0, 31'd7, 32'h0000_0007, 1'b0, done_seen);
		feed(5'd1, KEY_MAX, '1, 1'b0, done_seen);
		feed(5'd0, KEY_MAX, 32'h0000_0001, 1'b0, done_seen);
		feed(5'd0, '0, '0, 1'b1, done_seen);
		feed(5'd0, '0, '0, 1'b1, done_seen);
		feed(5'd1, KEY_MAX, '1, 1'b1, done_seen);
		wait_idle();

		// zero acts as one way
		write_ways(6'd0);
		feed(5'd0, 31'd5, 32'hdead_beef, 1'b0, done_seen);
		feed(5'd1, 31'd1, 32'h0000_0002, 1'b0, done_seen);
		feed(5'd0, '0, '0, 1'b1, done_seen);
		feed(5'd1, '0, '0, 1'b1, done_seen);
		feed(5'd0, '0, '0, 1'b1, done_seen);
		wait_idle();

		phase = 0;
		while (plan_words < RANDOM_WORDS) begin
			case (phase)
				0: v = 6'd32;
				1: v = 6'd63;
				2: v = 6'd1;
				3: v = 6'd33;
				4: v = WAYS_IN_USE_RST;
				default: begin
					case ($urandom_range(0, 19))
						0: v = 6'd0;
						1: v = 6'd32;
						2: v = CFG_W'($urandom_range(33, 63));
						3, 4, 5, 6: v = CFG_W'($urandom_range(9, 32));
						default: v = CFG_W'($urandom_range(1, 8));
					endcase
				end
			endcase
			write_ways(v);
			// a short budget leaves a merge open across the next setting change
			repeat ($urandom_range(1, 3))
				gen_merge(($urandom_range(0, 5) == 0) ? $urandom_range(5, 40) : 2000);
			wait_idle();
			phase++;
		end

		if (expected_emits.size() != 0) begin
			$display("%0t ns: %0d result words never arrived", $time, expected_emits.size());
			errors++;
		end
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
